FILE: hw/rtl/rar_pkg.sv
// Package: payload types and opcodes for the fraction arithmetic block.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
    localparam int unsigned OpW = 16;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [OpW-1:0]   first_numerator;
        logic [OpW-2:0]          first_denominator;
        logic signed [OpW-1:0]   second_numerator;
        logic [OpW-2:0]          second_denominator;
    } t_in;

    typedef struct packed {
        logic signed [2*OpW-1:0] result_numerator;
        logic [2*OpW-2:0]        result_denominator;
        logic                    status;
    } t_out;
endpackage
`default_nettype wire

FILE: hw/rtl/rar_divu.sv
// Bit-serial unsigned restoring divider: quotient and remainder, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rar_divu #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quot,
    output logic [W-1:0]      o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    n_sh, n_diff;

    assign n_sh   = {r_r[W-1:0], r_q[W-1]};
    assign n_diff = n_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
            end else if (r_busy) begin
                if (n_diff[W]) begin
                    r_r <= n_sh;
                    r_q <= {r_q[W-2:0], 1'b0};
                end else begin
                    r_r <= n_diff;
                    r_q <= {r_q[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[W-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/rational_arith_reduce_top.sv
// Top level: fraction add/sub/mul/div with gcd reduction to lowest terms.
//
//  channel | ports                      | handshake
//  in      | i_start, i_in, o_busy      | transfer when i_start && !o_busy
//  out     | o_valid, o_out             | one-cycle strobe, no back-pressure
//
// One shared bit-serial divider computes each Euclid remainder of the gcd and
// both final quotients; each use takes a start state (S_*_GO) and a wait state
// (S_*_WAIT) until its done pulse. Zero or error results strobe from S_FORM
// without using the divider. Reset is synchronous; o_busy stays high from
// acceptance until the result strobe, during which the next item can transfer.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire rar_pkg::t_in i_in,
    output logic              o_busy,
    output logic              o_valid,
    output rar_pkg::t_out     o_out
);
    localparam int OW = rar_pkg::OpW;
    localparam int W  = 2 * OW;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_FORM, S_GCD_GO, S_GCD_WAIT,
        S_DN_GO, S_DN_WAIT, S_DD_GO, S_DD_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0]            r_func;
    logic signed [OW-1:0]  r_n1, r_n2;
    logic [OW-2:0]         r_d1, r_d2;
    logic signed [W:0]     r_p1, r_p2, r_den;
    logic signed [W+1:0]   r_num;
    logic [W-1:0]          r_mag, r_dmag, r_a, r_b, r_g, r_qn;
    logic                  r_neg;
    logic                  dv_start, dv_done;
    logic [W-1:0]          dv_a, dv_b, dv_q, dv_r;
    logic signed [W+1:0]   n_num;
    logic signed [W:0]     n_den;
    logic signed [OW:0]    sd1, sd2;

    rar_divu #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_dividend(dv_a), .i_divisor(dv_b),
        .o_done(dv_done), .o_quot(dv_q), .o_rem(dv_r)
    );

    assign sd1 = $signed({2'b00, r_d1});
    assign sd2 = $signed({2'b00, r_d2});

    always_comb begin
        dv_start = (r_state == S_GCD_GO) || (r_state == S_DN_GO)
                || (r_state == S_DD_GO);
        dv_a = r_a;
        dv_b = r_b;
        if (r_state == S_DN_GO) begin
            dv_a = r_mag;
            dv_b = r_g;
        end else if (r_state == S_DD_GO) begin
            dv_a = r_dmag;
            dv_b = r_g;
        end
        case (r_func)
            rar_pkg::FUNC_ADD: n_num = (W+2)'(r_p1) + (W+2)'(r_p2);
            rar_pkg::FUNC_SUB: n_num = (W+2)'(r_p1) - (W+2)'(r_p2);
            default:           n_num = (W+2)'(r_p1);
        endcase
        n_den = r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_func  <= i_in.func;
                    r_n1    <= OW'(i_in.first_numerator);
                    r_d1    <= (OW-1)'(i_in.first_denominator);
                    r_n2    <= OW'(i_in.second_numerator);
                    r_d2    <= (OW-1)'(i_in.second_denominator);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    // numerator product r_p1 and denominator product r_den; r_p2 follows in S_MUL2
                    if (r_func == rar_pkg::FUNC_MUL) r_p1 <= (W+1)'(r_n1 * r_n2);
                    else                             r_p1 <= (W+1)'(r_n1 * sd2);
                    if (r_func == rar_pkg::FUNC_DIV) r_den <= (W+1)'(sd1 * r_n2);
                    else                             r_den <= (W+1)'(sd1 * sd2);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= (W+1)'(r_n2 * sd1);
                    r_state <= S_FORM;
                end
                S_FORM: begin
                    if (n_den == '0) begin
                        o_out   <= '{result_numerator: '0, result_denominator: '0,
                                     status: 1'b1};
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_num <= n_den[W] ? -n_num : n_num;
                        r_dmag <= W'(n_den[W] ? -n_den : n_den);
                        if (n_num == '0) begin
                            o_out   <= '{result_numerator: '0,
                                         result_denominator: (W-1)'(1), status: 1'b0};
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    r_neg   <= r_num[W+1];
                    r_mag   <= W'(r_num[W+1] ? -r_num : r_num);
                    r_a     <= W'(r_num[W+1] ? -r_num : r_num);
                    r_b     <= r_dmag;
                    r_state <= S_GCD_GO;
                end
                S_GCD_GO: r_state <= S_GCD_WAIT;
                S_GCD_WAIT: if (dv_done) begin
                    if (dv_r == '0) begin
                        r_g     <= r_b;
                        r_state <= S_DN_GO;
                    end else begin
                        r_a     <= r_b;
                        r_b     <= dv_r;
                        r_state <= S_GCD_GO;
                    end
                end
                S_DN_GO:   r_state <= S_DN_WAIT;
                S_DN_WAIT: if (dv_done) begin
                    r_qn    <= dv_q;
                    r_state <= S_DD_GO;
                end
                S_DD_GO:   r_state <= S_DD_WAIT;
                S_DD_WAIT: if (dv_done) begin
                    o_out.result_numerator   <= W'(r_neg ? -r_qn : r_qn);
                    o_out.result_denominator <= (W-1)'(dv_q);
                    o_out.status             <= 1'b0;
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

FILE: verif/rational_arith_reduce_top_tb.sv
// Testbench: fraction add/sub/mul/div with reduction, checked against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_top_tb;
    localparam int WDOG_LIMIT = 20000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    rar_pkg::t_in   i_in;
    logic           o_busy;
    logic           o_valid;
    rar_pkg::t_out  o_out;

    rar_pkg::t_out  expected_fracs[$];
    int    n_errors;
    int    idle_cycles;
    bit    no_gaps;

    rational_arith_reduce_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic rar_pkg::t_out reduce_fraction(rar_pkg::t_in x);
        rar_pkg::t_out r;
        longint n1, d1, n2, d2, num, den, a, b, t;
        n1 = longint'(x.first_numerator);
        d1 = longint'({1'b0, x.first_denominator});
        n2 = longint'(x.second_numerator);
        d2 = longint'({1'b0, x.second_denominator});
        case (rar_pkg::t_func'(x.func))
            rar_pkg::FUNC_ADD: begin num = n1 * d2 + n2 * d1; den = d1 * d2; end
            rar_pkg::FUNC_SUB: begin num = n1 * d2 - n2 * d1; den = d1 * d2; end
            rar_pkg::FUNC_MUL: begin num = n1 * n2; den = d1 * d2; end
            default:           begin num = n1 * d2; den = d1 * n2; end
        endcase
        r = '0;
        if (den == 0) begin
            r.status = 1'b1;
            return r;
        end
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num == 0) begin
            r.result_denominator = 31'd1;
            return r;
        end
        a = (num < 0) ? -num : num;
        b = den;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        r.result_numerator   = 32'(num / a);
        r.result_denominator = 31'(den / a);
        return r;
    endfunction

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
        if (i_rst_n && o_valid) begin
            if (expected_fracs.size() == 0) begin
                $error("unexpected result %h", o_out);
                n_errors++;
            end else begin
                rar_pkg::t_out e;
                e = expected_fracs.pop_front();
                if (o_out.result_numerator !== e.result_numerator) begin
                    $error("result_numerator exp %0d got %0d",
                           e.result_numerator, o_out.result_numerator);
                    n_errors++;
                end
                if (o_out.result_denominator !== e.result_denominator) begin
                    $error("result_denominator exp %0d got %0d",
                           e.result_denominator, o_out.result_denominator);
                    n_errors++;
                end
                if (o_out.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out.status);
                    n_errors++;
                end
            end
        end
    end

    // start stays high after a transfer so the next item can follow directly;
    // it drops only on an idle cycle or when draining
    task automatic send_op(rar_pkg::t_func f, logic [15:0] n1, logic [14:0] d1,
                           logic [15:0] n2, logic [14:0] d2);
        rar_pkg::t_in x;
        x.func               = f;
        x.first_numerator    = n1;
        x.first_denominator  = d1;
        x.second_numerator   = n2;
        x.second_denominator = d2;
        while (!no_gaps && $urandom_range(99) < 21) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= x;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        expected_fracs.push_back(reduce_fraction(x));
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (expected_fracs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [14:0] rand_den();
        case ($urandom_range(3))
            0: return 15'($urandom_range(1, 8));
            1: return 15'h7fff - 15'($urandom_range(3));
            default: return 15'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [15:0] rand_num();
        case ($urandom_range(4))
            0: return 16'($signed($urandom_range(8)) - 4);
            1: return 16'h8000 + 16'($urandom_range(2));
            2: return 16'h7fff - 16'($urandom_range(2));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        for (int f = 0; f < 4; f++) begin
            send_op(rar_pkg::t_func'(f), 16'sd1, 15'd2, 16'sd1, 15'd3);
            send_op(rar_pkg::t_func'(f), 16'h8000, 15'h7fff, 16'h8000, 15'd1);
            send_op(rar_pkg::t_func'(f), 16'h7fff, 15'd1, -16'sd7, 15'h7fff);
        end
        // zero result numerator
        send_op(rar_pkg::FUNC_SUB, 16'sd3, 15'd4, 16'sd6, 15'd8);
        send_op(rar_pkg::FUNC_MUL, 16'sd0, 15'd5, 16'sd9, 15'd7);
        // divide by zero fraction
        send_op(rar_pkg::FUNC_DIV, 16'sd5, 15'd3, 16'sd0, 15'd2);
        // divide by negative fraction
        send_op(rar_pkg::FUNC_DIV, 16'sd4, 15'd9, -16'sd6, 15'd3);
        // zero input denominator
        send_op(rar_pkg::FUNC_ADD, 16'sd3, 15'd0, 16'sd1, 15'd2);
        send_op(rar_pkg::FUNC_MUL, 16'sd3, 15'd4, 16'sd1, 15'd0);
        send_op(rar_pkg::FUNC_DIV, 16'sd3, 15'd0, 16'sd1, 15'd2);
        send_op(rar_pkg::FUNC_ADD, 16'hffff, 15'h5555, 16'h5555, 15'h2aaa);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            no_gaps = (k >= 300 && k < 450);
            send_op(rar_pkg::t_func'($urandom_range(3)), rand_num(), rand_den(),
                    rand_num(), rand_den());
            if (k == 600) wait_drained();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_in        = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1130);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
